[design/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and timing constants for the LCD timing and STAT interrupt block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lts_pkg;

    // Line and frame timing
    localparam int DOTS_PER_LINE = 456;
    localparam int VISIBLE_LINES = 144;
    localparam int TOTAL_LINES   = 154;
    localparam int SEARCH_DOTS   = 80;
    localparam int TRANSFER_DOTS = 172;

    localparam logic [8:0] SEARCH_LAST   = 9'(SEARCH_DOTS - 1);
    localparam logic [8:0] TRANSFER_LAST = 9'(TRANSFER_DOTS - 1);
    localparam logic [8:0] LINE_LAST     = 9'(DOTS_PER_LINE - 1);
    localparam logic [7:0] VISIBLE_LIM   = 8'(VISIBLE_LINES);
    localparam logic [7:0] TOTAL_LIM     = 8'(TOTAL_LINES);

    // LCDC display enable bit
    localparam int LCD_ON_BIT = 7;

    // STAT read constant bit and open-bus value
    localparam logic [7:0] STAT_FIXED = 8'h80;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    // Register offsets within the display block
    localparam logic [3:0] OFF_LCDC = 4'd0;
    localparam logic [3:0] OFF_STAT = 4'd1;
    localparam logic [3:0] OFF_SCY  = 4'd2;
    localparam logic [3:0] OFF_SCX  = 4'd3;
    localparam logic [3:0] OFF_LY   = 4'd4;
    localparam logic [3:0] OFF_LYC  = 4'd5;
    localparam logic [3:0] OFF_BGP  = 4'd7;
    localparam logic [3:0] OFF_OBP0 = 4'd8;
    localparam logic [3:0] OFF_OBP1 = 4'd9;
    localparam logic [3:0] OFF_WY   = 4'd10;
    localparam logic [3:0] OFF_WX   = 4'd11;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } lts_op_t;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } lts_mode_t;

    // One result per request
    typedef struct packed {
        logic [7:0] current_line;
        lts_mode_t  display_mode;
        logic       frame_done;
        logic       stat_irq;
        logic       vblank_irq;
        logic [7:0] read_data;
    } lts_result_t;

endpackage

[design/lts_core.sv]
// ----------------------------------------------------------------------------
// lts_core
// Register file, dot/line sequencer and STAT edge detector. Updates state on
// each accepted request and presents that request's result combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lts_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           operation,
    input  logic [3:0]           reg_offset,
    input  logic [7:0]           write_data,
    output lts_pkg::lts_result_t result
);

    typedef struct packed {
        logic coin;
        logic cond;
        logic rise;
    } eval_t;

    lts_pkg::lts_mode_t mode_reg, mode_next;
    logic [7:0] line_reg, line_next;
    logic [8:0] mdots_reg, mdots_next;
    logic [8:0] ldots_reg, ldots_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [3:0] en_reg, en_next;
    logic       coin_reg, coin_next;
    logic       prev_reg, prev_next;
    logic [7:0] scy_reg, scy_next;
    logic [7:0] scx_reg, scx_next;
    logic [7:0] lyc_reg, lyc_next;
    logic [7:0] bgp_reg, bgp_next;
    logic [7:0] obp0_reg, obp0_next;
    logic [7:0] obp1_reg, obp1_next;
    logic [7:0] wy_reg, wy_next;
    logic [7:0] wx_reg, wx_next;

    logic [7:0] rd;
    logic       vbl, stat, done, advanced;
    eval_t      ev;

    // Evaluate the combined STAT condition and its rising edge
    function automatic eval_t eval_stat(input logic [7:0] line, input logic [7:0] lyc,
                                        input logic [3:0] en, input lts_pkg::lts_mode_t mode,
                                        input logic prev);
        eval_t e;
        e.coin = (line == lyc);
        e.cond = (en[3] & e.coin)
               | (en[2] & (mode == lts_pkg::MODE_SEARCH))
               | (en[1] & (mode == lts_pkg::MODE_VBLANK))
               | (en[0] & (mode == lts_pkg::MODE_HBLANK));
        e.rise = e.cond & ~prev;
        return e;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        mdots_next = mdots_reg;
        ldots_next = ldots_reg;
        ctrl_next  = ctrl_reg;
        en_next    = en_reg;
        coin_next  = coin_reg;
        prev_next  = prev_reg;
        scy_next   = scy_reg;
        scx_next   = scx_reg;
        lyc_next   = lyc_reg;
        bgp_next   = bgp_reg;
        obp0_next  = obp0_reg;
        obp1_next  = obp1_reg;
        wy_next    = wy_reg;
        wx_next    = wx_reg;
        rd         = 8'h00;
        vbl        = 1'b0;
        stat       = 1'b0;
        done       = 1'b0;
        advanced   = 1'b0;
        ev         = '0;

        case (operation)
            lts_pkg::OP_TICK:
            begin
                if (ctrl_reg[lts_pkg::LCD_ON_BIT])
                begin
                    case (mode_reg)
                        lts_pkg::MODE_SEARCH:
                        begin
                            if (mdots_reg >= lts_pkg::SEARCH_LAST)
                            begin
                                mode_next  = lts_pkg::MODE_TRANSFER;
                                mdots_next = '0;
                                ldots_next = ldots_reg + 9'd1;
                                ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                                coin_next = ev.coin;
                                prev_next = ev.cond;
                                stat      = stat | ev.rise;
                                advanced  = 1'b1;
                            end
                        end
                        lts_pkg::MODE_TRANSFER:
                        begin
                            if (mdots_reg >= lts_pkg::TRANSFER_LAST)
                            begin
                                mode_next  = lts_pkg::MODE_HBLANK;
                                mdots_next = '0;
                                ldots_next = ldots_reg + 9'd1;
                                ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                                coin_next = ev.coin;
                                prev_next = ev.cond;
                                stat      = stat | ev.rise;
                                advanced  = 1'b1;
                            end
                        end
                        lts_pkg::MODE_HBLANK:
                        begin
                            if (ldots_reg >= lts_pkg::LINE_LAST)
                            begin
                                line_next  = line_reg + 8'd1;
                                mdots_next = '0;
                                ldots_next = '0;
                                if (line_next >= lts_pkg::VISIBLE_LIM)
                                begin
                                    mode_next = lts_pkg::MODE_VBLANK;
                                    vbl       = 1'b1;
                                end
                                else
                                begin
                                    mode_next = lts_pkg::MODE_SEARCH;
                                end
                                ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                                coin_next = ev.coin;
                                prev_next = ev.cond;
                                stat      = stat | ev.rise;
                                advanced  = 1'b1;
                            end
                        end
                        default:
                        begin
                            // VBlank: step one line per line time, wrap at frame end
                            if (ldots_reg >= lts_pkg::LINE_LAST)
                            begin
                                line_next  = line_reg + 8'd1;
                                ldots_next = '0;
                                mdots_next = mdots_reg + 9'd1;
                                ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                                coin_next = ev.coin;
                                prev_next = ev.cond;
                                stat      = stat | ev.rise;
                                if (line_next >= lts_pkg::TOTAL_LIM)
                                begin
                                    done       = 1'b1;
                                    line_next  = 8'd0;
                                    mdots_next = '0;
                                    ldots_next = '0;
                                    if (line_next >= lts_pkg::VISIBLE_LIM)
                                    begin
                                        mode_next = lts_pkg::MODE_VBLANK;
                                        vbl       = 1'b1;
                                    end
                                    else
                                    begin
                                        mode_next = lts_pkg::MODE_SEARCH;
                                    end
                                    ev = eval_stat(line_next, lyc_next, en_next, mode_next,
                                                   prev_next);
                                    coin_next = ev.coin;
                                    prev_next = ev.cond;
                                    stat      = stat | ev.rise;
                                end
                                advanced = 1'b1;
                            end
                        end
                    endcase
                    if (!advanced)
                    begin
                        mdots_next = mdots_reg + 9'd1;
                        ldots_next = ldots_reg + 9'd1;
                    end
                end
            end
            lts_pkg::OP_READ:
            begin
                case (reg_offset)
                    lts_pkg::OFF_LCDC: rd = ctrl_reg;
                    lts_pkg::OFF_STAT:
                    begin
                        rd = lts_pkg::STAT_FIXED | {1'b0, en_reg, 3'b000};
                        if (ctrl_reg[lts_pkg::LCD_ON_BIT])
                        begin
                            rd = rd | {5'b00000, coin_reg, mode_reg};
                        end
                    end
                    lts_pkg::OFF_SCY:  rd = scy_reg;
                    lts_pkg::OFF_SCX:  rd = scx_reg;
                    lts_pkg::OFF_LY:   rd = line_reg;
                    lts_pkg::OFF_LYC:  rd = lyc_reg;
                    lts_pkg::OFF_BGP:  rd = bgp_reg;
                    lts_pkg::OFF_OBP0: rd = obp0_reg;
                    lts_pkg::OFF_OBP1: rd = obp1_reg;
                    lts_pkg::OFF_WY:   rd = wy_reg;
                    lts_pkg::OFF_WX:   rd = wx_reg;
                    default:           rd = lts_pkg::OPEN_BUS;
                endcase
            end
            lts_pkg::OP_WRITE:
            begin
                case (reg_offset)
                    lts_pkg::OFF_LCDC:
                    begin
                        ctrl_next = write_data;
                        // Switch-off: park at line 0 in HBlank
                        if (!write_data[lts_pkg::LCD_ON_BIT] && ctrl_reg[lts_pkg::LCD_ON_BIT])
                        begin
                            line_next  = 8'd0;
                            done       = 1'b1;
                            mode_next  = lts_pkg::MODE_HBLANK;
                            mdots_next = '0;
                            ldots_next = '0;
                            ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                            coin_next = ev.coin;
                            prev_next = ev.cond;
                            stat      = stat | ev.rise;
                        end
                    end
                    lts_pkg::OFF_STAT:
                    begin
                        en_next = write_data[6:3];
                        ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                        coin_next = ev.coin;
                        prev_next = ev.cond;
                        stat      = stat | ev.rise;
                    end
                    lts_pkg::OFF_SCY:  scy_next = write_data;
                    lts_pkg::OFF_SCX:  scx_next = write_data;
                    lts_pkg::OFF_LYC:
                    begin
                        lyc_next = write_data;
                        ev = eval_stat(line_next, lyc_next, en_next, mode_next, prev_next);
                        coin_next = ev.coin;
                        prev_next = ev.cond;
                        stat      = stat | ev.rise;
                    end
                    lts_pkg::OFF_BGP:  bgp_next  = write_data;
                    lts_pkg::OFF_OBP0: obp0_next = write_data;
                    lts_pkg::OFF_OBP1: obp1_next = write_data;
                    lts_pkg::OFF_WY:   wy_next   = write_data;
                    lts_pkg::OFF_WX:   wx_next   = write_data;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign result.read_data    = rd;
    assign result.vblank_irq   = vbl;
    assign result.stat_irq     = stat;
    assign result.frame_done   = done;
    assign result.display_mode = mode_next;
    assign result.current_line = line_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lts_pkg::MODE_SEARCH;
            line_reg  <= '0;
            mdots_reg <= '0;
            ldots_reg <= '0;
            ctrl_reg  <= '0;
            en_reg    <= '0;
            coin_reg  <= 1'b0;
            prev_reg  <= 1'b0;
            scy_reg   <= '0;
            scx_reg   <= '0;
            lyc_reg   <= '0;
            bgp_reg   <= '0;
            obp0_reg  <= '0;
            obp1_reg  <= '0;
            wy_reg    <= '0;
            wx_reg    <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            mdots_reg <= mdots_next;
            ldots_reg <= ldots_next;
            ctrl_reg  <= ctrl_next;
            en_reg    <= en_next;
            coin_reg  <= coin_next;
            prev_reg  <= prev_next;
            scy_reg   <= scy_next;
            scx_reg   <= scx_next;
            lyc_reg   <= lyc_next;
            bgp_reg   <= bgp_next;
            obp0_reg  <= obp0_next;
            obp1_reg  <= obp1_next;
            wy_reg    <= wy_next;
            wx_reg    <= wx_next;
        end
    end

endmodule

[design/lcd_timing_stat_interrupt_top.sv]
// ----------------------------------------------------------------------------
// lcd_timing_stat_interrupt_top
// LCD timing sequencer, display register file and STAT/VBlank interrupts.
// Throughput: one request per cycle while the skid slot is empty; set by the
// single-pass state update. Each result is registered in a two-entry output stage
// (result register plus skid) that keeps input open while one result waits.
// Reset clears core state and valid flags; mode starts in OAM search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_timing_stat_interrupt_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] reg_offset, [11:4] write_data, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] read_data, [8] vblank_irq, [9] stat_irq,
                                   // [10] frame_done, [12:11] display_mode,
                                   // [20:13] current_line, [23:21] zero
);

    lts_pkg::lts_result_t core_res;
    lts_pkg::lts_result_t out_reg, out_next;
    lts_pkg::lts_result_t skid_reg, skid_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic                 accept;
    logic                 out_free;

    // Take a request whenever the skid slot is empty
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Sequencer and register file; state advances on each accepted request
    lts_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (s_tuser),
        .reg_offset (s_tdata[3:0]),
        .write_data (s_tdata[11:4]),
        .result     (core_res)
    );

    // Output register drains or is empty this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // Advance the parked result; no request is taken this cycle
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = core_res;
                out_valid_next = accept;
            end
        end
        else if (accept)
        begin
            // Hold the new result in the skid slot while output stalls
            skid_next       = core_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.current_line, out_reg.display_mode,
                       out_reg.frame_done, out_reg.stat_irq, out_reg.vblank_irq,
                       out_reg.read_data};

    // A parked result always sits behind a valid output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    // VBlank interrupt only on entry into VBlank
    a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.vblank_irq) |->
        (out_reg.display_mode == lts_pkg::MODE_VBLANK))
        else $error("vblank_irq without VBlank mode");

    // Frame end and switch-off both leave LY at line 0
    a_done_line0: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.frame_done) |-> (out_reg.current_line == 8'd0))
        else $error("frame_done with nonzero line");

    // LY never passes the last VBlank line
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.current_line < lts_pkg::TOTAL_LIM))
        else $error("line number out of range");

endmodule

[sim/lcd_timing_stat_interrupt_checker.sv]
// ----------------------------------------------------------------------------
// lcd_timing_stat_interrupt_checker
// Watches both stream channels and predicts each result of the LCD timing block.
// Compares each result field by field and reports the failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_timing_stat_interrupt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] reg_offset, [11:4] write_data, [15:12] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] read_data, [8] vblank_irq, [9] stat_irq,
                                   // [10] frame_done, [12:11] display_mode,
                                   // [20:13] current_line, [23:21] zero
    output int          fail_count,
    output int          pending
);

    // Predicted controller state
    lts_pkg::lts_mode_t   mode_q;
    logic [7:0]           ly_q;
    logic [8:0]           mode_dots_q;
    logic [8:0]           line_dots_q;
    logic [7:0]           lcdc_q;
    logic [3:0]           stat_en_q;
    logic                 coinc_q;
    logic                 cond_prev_q;
    logic [7:0]           scy_q;
    logic [7:0]           scx_q;
    logic [7:0]           lyc_q;
    logic [7:0]           pal_q [3];
    logic [7:0]           win_q [2];

    lts_pkg::lts_result_t lcd_status_q [$];
    lts_pkg::lts_result_t got;
    lts_pkg::lts_result_t want;
    int                   issued;
    int                   retired;

    assign pending = issued - retired;

    // Refresh the coincidence flag and return 1 on a rising STAT condition.
    function automatic logic stat_rise();
        logic cond;
        coinc_q = (ly_q == lyc_q);
        cond = (stat_en_q[3] && coinc_q)
            || (stat_en_q[2] && mode_q == lts_pkg::MODE_SEARCH)
            || (stat_en_q[1] && mode_q == lts_pkg::MODE_VBLANK)
            || (stat_en_q[0] && mode_q == lts_pkg::MODE_HBLANK);
        stat_rise = cond && !cond_prev_q;
        cond_prev_q = cond;
    endfunction

    function automatic logic start_line(inout logic vbl);
        ly_q = ly_q + 8'd1;
        mode_dots_q = '0;
        line_dots_q = '0;
        if (ly_q >= lts_pkg::VISIBLE_LIM)
        begin
            mode_q = lts_pkg::MODE_VBLANK;
            vbl = 1'b1;
        end
        else
        begin
            mode_q = lts_pkg::MODE_SEARCH;
        end
        return stat_rise();
    endfunction

    function automatic lts_pkg::lts_result_t lcd_timing_step(input logic [1:0] op,
                                                            input logic [3:0] off,
                                                            input logic [7:0] data);
        lts_pkg::lts_result_t r;
        logic                 advanced;
        logic                 vbl;
        logic                 rise;
        logic                 done;
        r = '0;
        vbl = 1'b0;
        rise = 1'b0;
        done = 1'b0;
        advanced = 1'b0;
        case (op)
            lts_pkg::OP_TICK:
            begin
                if (lcdc_q[lts_pkg::LCD_ON_BIT])
                begin
                    case (mode_q)
                        lts_pkg::MODE_SEARCH:
                        begin
                            if (mode_dots_q >= lts_pkg::SEARCH_LAST)
                            begin
                                mode_q = lts_pkg::MODE_TRANSFER;
                                mode_dots_q = '0;
                                line_dots_q = line_dots_q + 9'd1;
                                rise = rise | stat_rise();
                                advanced = 1'b1;
                            end
                        end
                        lts_pkg::MODE_TRANSFER:
                        begin
                            if (mode_dots_q >= lts_pkg::TRANSFER_LAST)
                            begin
                                mode_q = lts_pkg::MODE_HBLANK;
                                mode_dots_q = '0;
                                line_dots_q = line_dots_q + 9'd1;
                                rise = rise | stat_rise();
                                advanced = 1'b1;
                            end
                        end
                        lts_pkg::MODE_HBLANK:
                        begin
                            if (line_dots_q >= lts_pkg::LINE_LAST)
                            begin
                                rise = rise | start_line(vbl);
                                advanced = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (line_dots_q >= lts_pkg::LINE_LAST)
                            begin
                                ly_q = ly_q + 8'd1;
                                line_dots_q = '0;
                                mode_dots_q = mode_dots_q + 9'd1;
                                rise = rise | stat_rise();
                                // past the last VBlank line: wrap to line 0
                                if (ly_q >= lts_pkg::TOTAL_LIM)
                                begin
                                    done = 1'b1;
                                    ly_q = 8'hFF;
                                    rise = rise | start_line(vbl);
                                end
                                advanced = 1'b1;
                            end
                        end
                    endcase
                    if (!advanced)
                    begin
                        mode_dots_q = mode_dots_q + 9'd1;
                        line_dots_q = line_dots_q + 9'd1;
                    end
                end
            end
            lts_pkg::OP_READ:
            begin
                case (off)
                    lts_pkg::OFF_LCDC: r.read_data = lcdc_q;
                    lts_pkg::OFF_STAT:
                    begin
                        r.read_data = lts_pkg::STAT_FIXED | {1'b0, stat_en_q, 3'b000};
                        if (lcdc_q[lts_pkg::LCD_ON_BIT])
                            r.read_data = r.read_data | {5'b0, coinc_q, mode_q};
                    end
                    lts_pkg::OFF_SCY: r.read_data = scy_q;
                    lts_pkg::OFF_SCX: r.read_data = scx_q;
                    lts_pkg::OFF_LY:  r.read_data = ly_q;
                    lts_pkg::OFF_LYC: r.read_data = lyc_q;
                    lts_pkg::OFF_BGP, lts_pkg::OFF_OBP0, lts_pkg::OFF_OBP1:
                        r.read_data = pal_q[2'(off - lts_pkg::OFF_BGP)];
                    lts_pkg::OFF_WY, lts_pkg::OFF_WX:
                        r.read_data = win_q[1'(off - lts_pkg::OFF_WY)];
                    default: r.read_data = lts_pkg::OPEN_BUS;
                endcase
            end
            lts_pkg::OP_WRITE:
            begin
                case (off)
                    lts_pkg::OFF_LCDC:
                    begin
                        // switch-off drops to line 0 in HBlank
                        if (!data[lts_pkg::LCD_ON_BIT] && lcdc_q[lts_pkg::LCD_ON_BIT])
                        begin
                            ly_q = '0;
                            done = 1'b1;
                            lcdc_q = data;
                            mode_q = lts_pkg::MODE_HBLANK;
                            mode_dots_q = '0;
                            line_dots_q = '0;
                            rise = rise | stat_rise();
                        end
                        else
                        begin
                            lcdc_q = data;
                        end
                    end
                    lts_pkg::OFF_STAT:
                    begin
                        stat_en_q = data[6:3];
                        rise = rise | stat_rise();
                    end
                    lts_pkg::OFF_SCY: scy_q = data;
                    lts_pkg::OFF_SCX: scx_q = data;
                    lts_pkg::OFF_LYC:
                    begin
                        lyc_q = data;
                        rise = rise | stat_rise();
                    end
                    lts_pkg::OFF_BGP, lts_pkg::OFF_OBP0, lts_pkg::OFF_OBP1:
                        pal_q[2'(off - lts_pkg::OFF_BGP)] = data;
                    lts_pkg::OFF_WY, lts_pkg::OFF_WX:
                        win_q[1'(off - lts_pkg::OFF_WY)] = data;
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.vblank_irq   = vbl;
        r.stat_irq     = rise;
        r.frame_done   = done;
        r.display_mode = mode_q;
        r.current_line = ly_q;
        return r;
    endfunction

    task automatic check_field(input string field, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_val, act_val);
            fail_count = fail_count + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = lts_pkg::MODE_SEARCH;
            ly_q = '0;
            mode_dots_q = '0;
            line_dots_q = '0;
            lcdc_q = '0;
            stat_en_q = '0;
            coinc_q = 1'b0;
            cond_prev_q = 1'b0;
            scy_q = '0;
            scx_q = '0;
            lyc_q = '0;
            pal_q = '{3{8'h00}};
            win_q = '{2{8'h00}};
            lcd_status_q.delete();
            issued <= 0;
            retired <= 0;
        end
        else
        begin
            // retire the oldest prediction first
            if (m_tvalid && m_tready)
            begin
                retired <= retired + 1;
                got = m_tdata[20:0];
                if (lcd_status_q.size() == 0)
                begin
                    $error("result 0x%06h arrived with no request outstanding", m_tdata);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = lcd_status_q.pop_front();
                    check_field("read_data", int'(want.read_data), int'(got.read_data));
                    check_field("vblank_irq", int'(want.vblank_irq), int'(got.vblank_irq));
                    check_field("stat_irq", int'(want.stat_irq), int'(got.stat_irq));
                    check_field("frame_done", int'(want.frame_done), int'(got.frame_done));
                    check_field("display_mode", int'(want.display_mode),
                                int'(got.display_mode));
                    check_field("current_line", int'(want.current_line),
                                int'(got.current_line));
                    check_field("tdata padding", 0, int'(m_tdata[23:21]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                issued <= issued + 1;
                lcd_status_q.push_back(lcd_timing_step(s_tuser, s_tdata[3:0],
                                                       s_tdata[11:4]));
            end
        end
    end

endmodule

[sim/lcd_timing_stat_interrupt_top_tb.sv]
// ----------------------------------------------------------------------------
// lcd_timing_stat_interrupt_top_tb
// Drives dot ticks and register requests into the LCD timing block and grades
// the run. A directed opening covers register corners, display switch-off and
// the unused operation; each of four handshake phases then streams ticks with
// sprinkled register traffic (the first phase runs past a full line), followed
// by a random request mix. The checker beside the block predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_timing_stat_interrupt_top_tb;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int LINE_RUN = lts_pkg::DOTS_PER_LINE + 44;
    localparam int SHORT_RUN = 150;
    localparam int MIX_PER_PHASE = 40;

    // Codes the package leaves unnamed: spare operation and unmapped offsets
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [3:0] OFF_DMA    = 4'd6;
    localparam logic [3:0] OFF_SPARE  = 4'd12;
    localparam logic [3:0] OFF_TOP    = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [3:0] reg_offset, [11:4] write_data, [15:12] zero
    logic [1:0]  s_tuser = '0;    // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [7:0] read_data, [8] vblank_irq, [9] stat_irq,
                                  // [10] frame_done, [12:11] display_mode,
                                  // [20:13] current_line, [23:21] zero

    int          fail_count;
    int          pending;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          requests_sent = 0;
    int          frame_ends = 0;
    int          vblank_irqs = 0;
    int          stat_irqs = 0;
    int unsigned cycle_count = 0;
    lts_pkg::lts_result_t seen;

    // Plans for the four handshake phases: none, sender idle, receiver stall, both
    int idle_plan  [4] = '{0, 50, 0, 29};
    int stall_plan [4] = '{0, 0, 50, 29};

    assign seen = m_tdata[20:0];

    always #HALF_PERIOD clk = ~clk;

    lcd_timing_stat_interrupt_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lcd_timing_stat_interrupt_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: drop tready at random for the current stall percentage
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Tally interrupt pulses for the closing summary
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            frame_ends  <= frame_ends + int'(seen.frame_done);
            vblank_irqs <= vblank_irqs + int'(seen.vblank_irq);
            stat_irqs   <= stat_irqs + int'(seen.stat_irq);
        end
    end

    // Watchdog: abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lcd_timing_stat_interrupt_top regression: fail");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it. Idle cycles
    // go in front, so tvalid stays high across back-to-back requests.
    task automatic send_req(input logic [1:0] op, input logic [3:0] off,
                            input logic [7:0] data);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, data, off};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent = requests_sent + 1;
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Switch the display on and stream ticks; sprinkle LYC, STAT and LY traffic
    // so coincidence and enable changes land across the early lines.
    task automatic send_frame_run(input int ticks);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LCDC, 8'h80 | 8'($urandom));
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_STAT, 8'($urandom));
        repeat (ticks)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LYC, 8'($urandom_range(0, 3)));
                    1: send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_STAT, 8'($urandom));
                    2: send_req(lts_pkg::OP_READ, lts_pkg::OFF_STAT, 8'($urandom));
                    default: send_req(lts_pkg::OP_READ, lts_pkg::OFF_LY, 8'($urandom));
                endcase
            end
            // tdata is ignored on a tick; fill it with noise anyway
            send_req(lts_pkg::OP_TICK, 4'($urandom), 8'($urandom));
        end
    endtask

    // Random mix of ticks, writes, reads and the spare operation code.
    task automatic send_random_mix(input int count);
        int         pick;
        logic [3:0] off;
        logic [7:0] data;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            off  = 4'($urandom);
            data = 8'($urandom);
            if (pick < 55)
            begin
                send_req(lts_pkg::OP_TICK, off, data);
            end
            else if (pick < 75)
            begin
                // keep the display on most of the time so ticks do work
                if (off == lts_pkg::OFF_LCDC && $urandom_range(0, 3) != 0)
                    data[lts_pkg::LCD_ON_BIT] = 1'b1;
                send_req(lts_pkg::OP_WRITE, off, data);
            end
            else if (pick < 95)
            begin
                send_req(lts_pkg::OP_READ, off, data);
            end
            else
            begin
                send_req(OP_UNUSED, off, data);
            end
        end
    endtask

    initial
    begin
        int phase;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening, display off after reset
        send_req(OP_UNUSED, lts_pkg::OFF_LCDC, 8'hFF);          // spare op: no effect
        send_req(lts_pkg::OP_TICK, lts_pkg::OFF_LCDC, 8'h00);   // tick with display off
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_LY, 8'h00);
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_STAT, 8'h00);   // display off: no mode bits
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_STAT, 8'hFF);  // all enables
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LYC, 8'h00);   // LY == LYC; STAT condition already high, no new edge
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LY, 8'h55);    // ignored
        send_req(lts_pkg::OP_WRITE, OFF_DMA, 8'hAA);            // ignored
        send_req(lts_pkg::OP_WRITE, OFF_TOP, 8'h5A);            // ignored
        send_req(lts_pkg::OP_READ, OFF_DMA, 8'h00);             // open bus
        send_req(lts_pkg::OP_READ, OFF_SPARE, 8'h00);           // open bus
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_BGP, 8'hFF);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_OBP1, 8'h00);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_WX, 8'hFF);
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_BGP, 8'h00);
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_WX, 8'h00);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LCDC, 8'h80);  // display on, OAM search
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_STAT, 8'h00);   // mode and coincidence visible
        send_req(lts_pkg::OP_TICK, OFF_TOP, 8'hFF);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LCDC, 8'h00);  // switch-off: frame_done
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LCDC, 8'h91);  // back on in HBlank
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_STAT, 8'h00);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_SCY, 8'hFF);
        send_req(lts_pkg::OP_READ, lts_pkg::OFF_SCY, 8'h00);
        send_req(lts_pkg::OP_WRITE, lts_pkg::OFF_LYC, 8'hFF);
        wait_drained();

        // First phase runs past a full line; each phase then mixes
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_plan[phase];
            stall_pct <= stall_plan[phase];
            send_frame_run(phase == 0 ? LINE_RUN : SHORT_RUN);
            send_random_mix(MIX_PER_PHASE);
            wait_drained();
        end

        // One result per request; let the output settle before the summary
        repeat (4) @(posedge clk);

        $display("Sent %0d requests over four handshake phases (ticks, reads, writes).",
                 requests_sent);
        $display("Observed %0d frame ends, %0d VBlank and %0d STAT interrupts.",
                 frame_ends, vblank_irqs, stat_irqs);
        if (fail_count == 0 && pending == 0)
            $display("lcd_timing_stat_interrupt_top regression: pass");
        else
            $display("lcd_timing_stat_interrupt_top regression: fail");
        $finish;
    end

endmodule
